/* hw/rtl/sacrr_pkg.sv */
// sacrr_pkg: shared types and constants for the set-associative cache unit.
// Holds the register map, field widths, state enums and the result record.
// No dependencies.
package sacrr_pkg;

	// configuration register map
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_SET_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WAY_COUNT = 2'd1;

	// register widths and reset values
	localparam int SET_COUNT_W = 9;
	localparam int WAY_COUNT_W = 4;
	localparam logic [SET_COUNT_W-1:0] SET_COUNT_RESET = 9'd256;
	localparam logic [WAY_COUNT_W-1:0] WAY_COUNT_RESET = 4'd1;

	// effective way count, wide enough to hold 16
	localparam int WCNT_W = 5;

	// result field widths
	localparam int SET_OUT_W = 8;
	localparam int WAY_OUT_W = 3;

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_DIV,
		FR_PUSH
	} fr_state_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_LOOKUP
	} bk_state_t;

	typedef struct packed {
		logic                 is_hit;
		logic [SET_OUT_W-1:0] set_index;
		logic [WAY_OUT_W-1:0] way_used;
		logic                 line_replaced;
	} result_t;

endpackage

/* hw/rtl/sacrr_front.sv */
// sacrr_front: accepts an address and splits it into set and tag.
// Restoring divider, one quotient bit per cycle. Uses sacrr_pkg.
module sacrr_front import sacrr_pkg::*; #(
	parameter int ADDR_BITS = 32,
	parameter int SET_W = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  logic [SET_COUNT_W-1:0] sets,
	input  logic [ADDR_BITS-1:0]   address,
	input  logic                   fifo_full,
	output logic                   busy,
	output logic                   push,
	output logic [SET_W-1:0]       push_set,
	output logic [ADDR_BITS-1:0]   push_tag
);

	localparam int CNT_W = $clog2(ADDR_BITS + 1);

	fr_state_t state_q, state_d;
	logic [ADDR_BITS-1:0]   quot_q;
	logic [SET_COUNT_W-1:0] rem_q;
	logic [SET_COUNT_W-1:0] div_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [SET_COUNT_W:0]   trial;
	logic [SET_COUNT_W:0]   diff;
	logic                   ge;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			FR_IDLE: begin
				if (accept) state_d = FR_DIV;
			end
			FR_DIV: begin
				if (cnt_q == CNT_W'(1)) state_d = FR_PUSH;
			end
			FR_PUSH: begin
				if (!fifo_full) state_d = FR_IDLE;
			end
			default: state_d = FR_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy = (state_q != FR_IDLE);
		push = (state_q == FR_PUSH) && !fifo_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// one divide step: shift in the next dividend bit, subtract if it fits
	assign trial = {rem_q, quot_q[ADDR_BITS-1]};
	assign ge    = (trial >= {1'b0, div_q});
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk) begin
		if (accept) begin
			quot_q <= address;
			rem_q  <= '0;
			div_q  <= sets;
			cnt_q  <= CNT_W'(ADDR_BITS);
		end else if (state_q == FR_DIV) begin
			quot_q <= {quot_q[ADDR_BITS-2:0], ge};
			rem_q  <= ge ? diff[SET_COUNT_W-1:0] : trial[SET_COUNT_W-1:0];
			cnt_q  <= cnt_q - 1'b1;
		end
	end

	assign push_set = SET_W'(rem_q);
	assign push_tag = quot_q;

endmodule

/* hw/rtl/sacrr_fifo.sv */
// sacrr_fifo: two-entry queue between the front and back halves.
// Standalone; no package needed.
module sacrr_fifo #(
	parameter int W = 40
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output logic         full,
	output logic         empty
);

	logic [W-1:0] mem_q [2];
	logic         wr_q, rd_q;
	logic [1:0]   cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

endmodule

/* hw/rtl/sacrr_back.sv */
// sacrr_back: tag lookup, fill and round-robin replacement over the line store.
// Clears valid bits and pointers after reset. Uses sacrr_pkg.
module sacrr_back import sacrr_pkg::*; #(
	parameter int MAX_SETS = 256,
	parameter int MAX_WAYS = 8,
	parameter int ADDR_BITS = 32,
	parameter int SET_W = 8,
	parameter int WAY_W = 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [WCNT_W-1:0]    ways,
	input  logic                 fifo_empty,
	input  logic [SET_W-1:0]     fifo_set,
	input  logic [ADDR_BITS-1:0] fifo_tag,
	output logic                 pop,
	output logic                 clearing,
	output logic                 res_valid,
	output result_t              res
);

	bk_state_t state_q, state_d;
	logic [SET_W-1:0] clr_q;

	// line store, one row per set
	logic [MAX_WAYS-1:0]                valid_mem [MAX_SETS];
	logic [WAY_W-1:0]                   ptr_mem   [MAX_SETS];
	logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tag_mem   [MAX_SETS];

	logic [MAX_WAYS-1:0]                vrow_s1;
	logic [WAY_W-1:0]                   prow_s1;
	logic [MAX_WAYS-1:0][ADDR_BITS-1:0] trow_s1;
	logic [SET_W-1:0]                   set_s1;
	logic [ADDR_BITS-1:0]               tag_s1;

	logic                               hit, free, replaced;
	logic [WAY_W-1:0]                   hit_way, free_way, victim, ptr_next, way;
	logic [WCNT_W-1:0]                  inc;
	logic [MAX_WAYS-1:0]                valid_new;
	logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tags_new;
	logic                               res_vld_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_CLEAR: begin
				if (clr_q == SET_W'(MAX_SETS - 1)) state_d = BK_IDLE;
			end
			BK_IDLE: begin
				if (!fifo_empty) state_d = BK_LOOKUP;
			end
			BK_LOOKUP: state_d = BK_IDLE;
			default:   state_d = BK_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		pop      = (state_q == BK_IDLE) && !fifo_empty;
		clearing = (state_q == BK_CLEAR);
	end

	// way search: lowest matching way, lowest free way, else round-robin victim
	always_comb begin
		hit      = 1'b0;
		hit_way  = '0;
		free     = 1'b0;
		free_way = '0;
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (WCNT_W'(w) < ways && vrow_s1[w] && trow_s1[w] == tag_s1) begin
				hit     = 1'b1;
				hit_way = WAY_W'(w);
			end
			if (WCNT_W'(w) < ways && !vrow_s1[w]) begin
				free     = 1'b1;
				free_way = WAY_W'(w);
			end
		end
		victim   = (WCNT_W'(prow_s1) >= ways) ? '0 : prow_s1;
		inc      = WCNT_W'(victim) + 1'b1;
		ptr_next = (inc == ways) ? '0 : WAY_W'(inc);
		replaced = !hit && !free;
		way      = hit ? hit_way : (free ? free_way : victim);
		valid_new      = vrow_s1 | (MAX_WAYS'(1) << way);
		tags_new       = trow_s1;
		tags_new[way]  = tag_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_CLEAR;
			clr_q     <= '0;
			res_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			res_vld_q <= (state_q == BK_LOOKUP);
			if (state_q == BK_CLEAR) clr_q <= clr_q + 1'b1;
		end
	end

	// store: registered row read on pop, row write on clear or miss
	always_ff @(posedge clk) begin
		if (state_q == BK_CLEAR) begin
			valid_mem[clr_q] <= '0;
			ptr_mem[clr_q]   <= '0;
		end else if (state_q == BK_LOOKUP && !hit) begin
			valid_mem[set_s1] <= valid_new;
			tag_mem[set_s1]   <= tags_new;
			if (replaced) ptr_mem[set_s1] <= ptr_next;
		end
		if (pop) begin
			vrow_s1 <= valid_mem[fifo_set];
			prow_s1 <= ptr_mem[fifo_set];
			trow_s1 <= tag_mem[fifo_set];
			set_s1  <= fifo_set;
			tag_s1  <= fifo_tag;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_LOOKUP) begin
			res.is_hit        <= hit;
			res.set_index     <= SET_OUT_W'(set_s1);
			res.way_used      <= WAY_OUT_W'(way);
			res.line_replaced <= replaced;
		end
	end

	assign res_valid = res_vld_q;

endmodule

/* hw/rtl/set_assoc_cache_round_robin_unit.sv */
// set_assoc_cache_round_robin_unit: set-associative lookup, round-robin replacement.
// Path: divider, queue, registered row read, lookup, then the registered result strobe.
// A new address is taken once the bit-serial divider has queued the previous one.
// Reset: asynchronous, active low; then a clearing pass over all MAX_SETS sets with busy high.
// Results are strobed for one cycle; the receiver cannot stall.
// Depends on sacrr_pkg, sacrr_front, sacrr_fifo, sacrr_back.
module set_assoc_cache_round_robin_unit import sacrr_pkg::*; #(
	parameter int MAX_SETS = 256,
	parameter int MAX_WAYS = 8,
	parameter int ADDR_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// item channel
	input  logic                   start,
	output logic                   busy,
	input  logic [ADDR_BITS-1:0]   address,
	// configuration write channel
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [SET_COUNT_W-1:0] cfg_data,
	// result channel
	output logic                   result_valid,
	output logic                   is_hit,
	output logic [SET_OUT_W-1:0]   set_index,
	output logic [WAY_OUT_W-1:0]   way_used,
	output logic                   line_replaced
);

	localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int ENTRY_W = SET_W + ADDR_BITS;

	logic [SET_COUNT_W-1:0] set_count_q;
	logic [WAY_COUNT_W-1:0] way_count_q;
	logic [SET_COUNT_W-1:0] sets_eff;
	logic [WCNT_W-1:0]      ways_eff;

	logic                 accept;
	logic                 fe_busy;
	logic                 clearing;
	logic                 push, pop, fifo_full, fifo_empty;
	logic [SET_W-1:0]     push_set;
	logic [ADDR_BITS-1:0] push_tag;
	logic [ENTRY_W-1:0]   pop_data;
	result_t              res;

	// Configuration. Writes must arrive only while idle; the block does not enforce this.
	// cfg_ready is tied high. An index beyond the two registers is accepted and dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_count_q <= SET_COUNT_RESET;
			way_count_q <= WAY_COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SET_COUNT: set_count_q <= cfg_data;
				CFG_WAY_COUNT: way_count_q <= cfg_data[WAY_COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Zero counts behave as one; counts above the build maxima saturate.
	always_comb begin
		if (set_count_q == '0)
			sets_eff = SET_COUNT_W'(1);
		else if (32'(set_count_q) > MAX_SETS)
			sets_eff = SET_COUNT_W'(MAX_SETS);
		else
			sets_eff = set_count_q;

		if (way_count_q == '0)
			ways_eff = WCNT_W'(1);
		else if (32'(way_count_q) > MAX_WAYS)
			ways_eff = WCNT_W'(MAX_WAYS);
		else
			ways_eff = WCNT_W'(way_count_q);
	end

	// Front end: takes one address, divides it by the set count bit by bit,
	// and queues {set, tag}. It holds busy until the entry is queued.
	assign busy   = fe_busy || clearing;
	assign accept = start && !busy;

	sacrr_front #(
		.ADDR_BITS (ADDR_BITS),
		.SET_W     (SET_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.sets      (sets_eff),
		.address   (address),
		.fifo_full (fifo_full),
		.busy      (fe_busy),
		.push      (push),
		.push_set  (push_set),
		.push_tag  (push_tag)
	);

	// Short queue so the divider can start the next address while the
	// back end is still doing a lookup.
	sacrr_fifo #(
		.W (ENTRY_W)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_set, push_tag}),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (fifo_full),
		.empty     (fifo_empty)
	);

	// Back end: row read, compare over the ways, fill or replace, result.
	// It pops no new entry during a lookup, and runs the clearing pass after reset.
	sacrr_back #(
		.MAX_SETS  (MAX_SETS),
		.MAX_WAYS  (MAX_WAYS),
		.ADDR_BITS (ADDR_BITS),
		.SET_W     (SET_W),
		.WAY_W     (WAY_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.ways       (ways_eff),
		.fifo_empty (fifo_empty),
		.fifo_set   (pop_data[ENTRY_W-1:ADDR_BITS]),
		.fifo_tag   (pop_data[ADDR_BITS-1:0]),
		.pop        (pop),
		.clearing   (clearing),
		.res_valid  (result_valid),
		.res        (res)
	);

	assign is_hit        = res.is_hit;
	assign set_index     = res.set_index;
	assign way_used      = res.way_used;
	assign line_replaced = res.line_replaced;

`ifndef SYNTHESIS
	// back end returns to idle after each lookup, so result strobes never come back to back
	a_result_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("back-to-back result strobes");

	// an accepted address always occupies the divider next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("front end idle after accepting a transaction");

	// a hit never reports a replacement
	a_hit_no_replace: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && is_hit) |-> !line_replaced)
		else $error("hit flagged as replacement");

	// nothing comes out while the store is being cleared
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> (!result_valid && !pop))
		else $error("lookup activity during clearing pass");
`endif

endmodule

/* tb/cache_lookup_checker.sv */
// cache_lookup_checker: watches the item, configuration and result channels of the cache unit,
// keeps its own copy of the tag store and victim pointers, and compares every result.
// Depends on sacrr_pkg.
`timescale 1ns / 100ps

module cache_lookup_checker import sacrr_pkg::*; #(
	parameter int MAX_SETS = 256,
	parameter int MAX_WAYS = 8,
	parameter int ADDR_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   busy,
	input  logic [ADDR_BITS-1:0]   address,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [SET_COUNT_W-1:0] cfg_data,
	input  logic                   result_valid,
	input  logic                   is_hit,
	input  logic [SET_OUT_W-1:0]   set_index,
	input  logic [WAY_OUT_W-1:0]   way_used,
	input  logic                   line_replaced,
	output int                     outstanding,
	output int                     failures
);

	logic [SET_COUNT_W-1:0] set_count_q;
	logic [WAY_COUNT_W-1:0] way_count_q;
	bit                     line_valid [MAX_SETS][MAX_WAYS];
	logic [ADDR_BITS-1:0]   line_tag [MAX_SETS][MAX_WAYS];
	int unsigned            victim_pointer [MAX_SETS];
	result_t                expected_lookups [$];
	result_t                oldest;
	int                     mismatch_count = 0;

	assign failures = mismatch_count;

	// lookup and update of the shadow tag store for one address
	function automatic result_t predict_lookup(input logic [ADDR_BITS-1:0] addr);
		logic [ADDR_BITS-1:0] divisor;
		logic [ADDR_BITS-1:0] tag;
		int unsigned          sets_used;
		int unsigned          ways_used;
		int unsigned          set_no;
		int unsigned          way_no;
		logic                 hit;
		logic                 filled;
		logic                 replaced;
		result_t              r;
		sets_used = (set_count_q == 0) ? 1 : (set_count_q > MAX_SETS) ? MAX_SETS : set_count_q;
		ways_used = (way_count_q == 0) ? 1 : (way_count_q > MAX_WAYS) ? MAX_WAYS : way_count_q;
		divisor = ADDR_BITS'(sets_used);
		set_no = addr % divisor;
		tag = addr / divisor;
		hit = 1'b0;
		filled = 1'b0;
		replaced = 1'b0;
		way_no = 0;
		for (int w = 0; w < ways_used && !hit; w++) begin
			if (line_valid[set_no][w] && line_tag[set_no][w] == tag) begin
				hit = 1'b1;
				way_no = w;
			end
		end
		if (!hit) begin
			for (int w = 0; w < ways_used && !filled; w++) begin
				if (!line_valid[set_no][w]) begin
					filled = 1'b1;
					way_no = w;
				end
			end
			if (!filled) begin
				// stale pointer beyond the ways in use falls back to way 0
				way_no = (victim_pointer[set_no] < ways_used) ? victim_pointer[set_no] : 0;
				replaced = 1'b1;
				victim_pointer[set_no] = (way_no + 1) % ways_used;
			end
			line_valid[set_no][way_no] = 1'b1;
			line_tag[set_no][way_no] = tag;
		end
		r.is_hit = hit;
		r.set_index = SET_OUT_W'(set_no);
		r.way_used = WAY_OUT_W'(way_no);
		r.line_replaced = replaced;
		return r;
	endfunction

	task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_count_q = SET_COUNT_RESET;
			way_count_q = WAY_COUNT_RESET;
			for (int s = 0; s < MAX_SETS; s++) begin
				victim_pointer[s] = 0;
				for (int w = 0; w < MAX_WAYS; w++) begin
					line_valid[s][w] = 1'b0;
					line_tag[s][w] = '0;
				end
			end
			expected_lookups.delete();
			outstanding <= 0;
		end else begin
			if (result_valid) begin
				if (expected_lookups.size() == 0) begin
					$display("%0t: result with no lookup outstanding, hit %0d set %0d way %0d repl %0d",
						$time, is_hit, set_index, way_used, line_replaced);
					mismatch_count++;
				end else begin
					oldest = expected_lookups.pop_front();
					check_field("is_hit", 8'(oldest.is_hit), 8'(is_hit));
					check_field("set_index", 8'(oldest.set_index), 8'(set_index));
					check_field("way_used", 8'(oldest.way_used), 8'(way_used));
					check_field("line_replaced", 8'(oldest.line_replaced), 8'(line_replaced));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SET_COUNT: begin
						set_count_q = cfg_data;
					end
					CFG_WAY_COUNT: begin
						way_count_q = cfg_data[WAY_COUNT_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (start && !busy)
				expected_lookups.push_back(predict_lookup(address));
			outstanding <= expected_lookups.size();
		end
	end

endmodule

/* tb/testbench.sv */
// testbench: stimulus and verdict for set_assoc_cache_round_robin_unit.
// Drives directed and random address streams across several cache geometries.
// Depends on sacrr_pkg, the cache unit RTL and cache_lookup_checker.
`timescale 1ns / 100ps

module testbench;
	import sacrr_pkg::*;

	localparam int MAX_SETS = 256;
	localparam int MAX_WAYS = 8;
	localparam int ADDR_BITS = 32;
	// register indexes the unit does not decode; writes to them must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
	// unit latency plus margin, used for the drain at the end
	localparam int DRAIN_CYCLES = ADDR_BITS + 8;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   start = 1'b0;
	logic                   busy;
	logic [ADDR_BITS-1:0]   address = '0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = CFG_SET_COUNT;
	logic [SET_COUNT_W-1:0] cfg_data = '0;
	logic                   result_valid;
	logic                   is_hit;
	logic [SET_OUT_W-1:0]   set_index;
	logic [WAY_OUT_W-1:0]   way_used;
	logic                   line_replaced;
	int                     outstanding;
	int                     failures;

	// 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	set_assoc_cache_round_robin_unit #(
		.MAX_SETS (MAX_SETS),
		.MAX_WAYS (MAX_WAYS),
		.ADDR_BITS(ADDR_BITS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.address      (address),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.is_hit       (is_hit),
		.set_index    (set_index),
		.way_used     (way_used),
		.line_replaced(line_replaced)
	);

	cache_lookup_checker #(
		.MAX_SETS (MAX_SETS),
		.MAX_WAYS (MAX_WAYS),
		.ADDR_BITS(ADDR_BITS)
	) lookup_monitor (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.address      (address),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.is_hit       (is_hit),
		.set_index    (set_index),
		.way_used     (way_used),
		.line_replaced(line_replaced),
		.outstanding  (outstanding),
		.failures     (failures)
	);

	// One address transaction. An idle gap drops start first; with no gap, start stays
	// high from the previous transaction so it is never lowered and raised in one step.
	// Always called just after a rising edge.
	task automatic send_address(input logic [ADDR_BITS-1:0] addr, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			address <= $urandom;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		address <= addr;
		do @(posedge clk); while (busy);
	endtask

	// Drop start and wait until every accepted transaction has returned its result.
	// outstanding is updated by nonblocking assignment, so it is read only after an edge.
	task automatic wait_idle();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Register write; cfg_valid stays high across a burst and drops after the last one.
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [SET_COUNT_W-1:0] data, input bit last);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (last)
			cfg_valid <= 1'b0;
	endtask

	// New geometry, written only once the unit has drained. Spare upper bits of the
	// way-count write carry junk, which the unit must ignore.
	task automatic program_geometry(input logic [SET_COUNT_W-1:0] sets,
			input logic [WAY_COUNT_W-1:0] ways);
		wait_idle();
		write_register(CFG_SET_COUNT, sets, 1'b0);
		write_register(CFG_WAY_COUNT, {5'($urandom_range(0, 31)), ways}, 1'b1);
	endtask

	logic [ADDR_BITS-1:0]   recent_addrs [$];
	logic [ADDR_BITS-1:0]   next_addr;
	logic [SET_COUNT_W-1:0] raw_sets;
	logic [WAY_COUNT_W-1:0] raw_ways;
	int unsigned            eff_sets;
	int unsigned            eff_ways;
	int unsigned            hot_base;
	int unsigned            choice;
	bit                     steady;

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// ---- directed part ----
		// Reset geometry: 256 sets, direct mapped. Miss, hit, top address miss then hit,
		// then two conflicting tags in set 0 forcing replacement of a valid line.
		send_address(32'd0, $urandom_range(0, 5));
		send_address(32'd0, $urandom_range(0, 5));
		send_address(32'hFFFF_FFFF, $urandom_range(0, 5));
		send_address(32'hFFFF_FFFF, $urandom_range(0, 5));
		send_address(32'd256, $urandom_range(0, 5));
		send_address(32'd0, $urandom_range(0, 5));

		// Two sets, two ways: lines from the old geometry are kept. Fill way 1, then
		// replace way 0, leaving the round-robin pointer of set 0 at 1.
		program_geometry(9'd2, 4'd2);
		send_address(32'd0, $urandom_range(0, 5));
		send_address(32'd2, $urandom_range(0, 5));
		send_address(32'd4, $urandom_range(0, 5));

		// Drop to one way: way 1 is no longer searched, and the pointer now sits beyond
		// the way count, so the victim must be way 0.
		wait_idle();
		write_register(CFG_WAY_COUNT, 9'd1, 1'b1);
		send_address(32'd2, $urandom_range(0, 5));
		send_address(32'd8, $urandom_range(0, 5));

		// Back to two ways; writes to undecoded indexes must leave the geometry alone.
		wait_idle();
		write_register(CFG_WAY_COUNT, 9'd2, 1'b0);
		write_register(CFG_SPARE_A, 9'h1FF, 1'b0);
		write_register(CFG_SPARE_B, 9'h000, 1'b1);
		send_address(32'd2, $urandom_range(0, 5));

		// Zero counts read as one; counts above the maximum saturate.
		program_geometry(9'd0, 4'd0);
		send_address(32'd5, $urandom_range(0, 5));
		send_address(32'd5, $urandom_range(0, 5));
		program_geometry(9'h1FF, 4'hF);
		send_address(32'hFFFF_FFFF, $urandom_range(0, 5));
		send_address(32'h8000_0000, $urandom_range(0, 5));

		// ---- random part ----
		// Each phase picks a geometry, the first few at the extremes, and mostly replays
		// recent addresses or builds conflicting tags in a few hot sets so that hits,
		// fills and round-robin replacement all occur; the rest is random or edge values.
		for (int phase = 0; phase < 12; phase++) begin
			case (phase)
				0: begin
					raw_sets = 9'd256;
					raw_ways = 4'd8;
				end
				1: begin
					raw_sets = 9'd1;
					raw_ways = 4'd1;
				end
				2: begin
					raw_sets = 9'h1FF;
					raw_ways = 4'hF;
				end
				3: begin
					raw_sets = 9'd1;
					raw_ways = 4'd8;
				end
				default: begin
					raw_sets = ($urandom_range(0, 3) == 0) ? SET_COUNT_W'($urandom_range(0, 511))
						: SET_COUNT_W'($urandom_range(1, 12));
					raw_ways = WAY_COUNT_W'($urandom_range(0, 15));
				end
			endcase
			program_geometry(raw_sets, raw_ways);
			eff_sets = (raw_sets == 0) ? 1 : (raw_sets > MAX_SETS) ? MAX_SETS : raw_sets;
			eff_ways = (raw_ways == 0) ? 1 : (raw_ways > MAX_WAYS) ? MAX_WAYS : raw_ways;
			hot_base = $urandom_range(0, eff_sets - 1);
			// every third phase runs back to back with no idle gaps
			steady = (phase % 3 == 1);
			repeat (120) begin
				choice = $urandom_range(0, 9);
				if (choice <= 4 && recent_addrs.size() > 0) begin
					next_addr = recent_addrs[$urandom_range(0, recent_addrs.size() - 1)];
				end else if (choice <= 7) begin
					next_addr = (hot_base + $urandom_range(0, 3)) % eff_sets
						+ eff_sets * $urandom_range(0, eff_ways + 3);
				end else if (choice == 8) begin
					next_addr = $urandom;
				end else begin
					next_addr = $urandom_range(0, 1) ? 32'hFFFF_FFFF - $urandom_range(0, 3)
						: $urandom_range(0, 3);
				end
				recent_addrs.push_back(next_addr);
				if (recent_addrs.size() > 12)
					void'(recent_addrs.pop_front());
				send_address(next_addr, steady ? 0 : $urandom_range(0, 5));
			end
		end

		// drain, then allow the unit's latency before the verdict
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	// watchdog: far beyond the slowest legal run, also catches results that never arrive
	initial begin
		#2_000_000;
		$display("testbench failed");
		$finish;
	end

endmodule
